// ===== src/wsd_pkg.sv =====
// Shared types and constants for the windowed stuck detector.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package wsd_pkg;

  localparam int ODO_DEPTH_DEF = 64;
  localparam int CMD_DEPTH_DEF = 64;

  localparam int TIME_W     = 32;
  localparam int POS_W      = 24;
  localparam int SPEED_W    = 17;
  localparam int MAG_W      = 16;
  localparam int THR_W      = 16;
  localparam int MOVE_W     = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int D2_W       = 2 * (POS_W + 1);
  localparam int ROOT_W     = D2_W / 2;
  localparam int REM_W      = ROOT_W + 2;

  localparam int MIN_ODO = 2;
  localparam int MIN_CMD = 3;

  localparam logic [1:0] KIND_ODO     = 2'd0;
  localparam logic [1:0] KIND_SPEED   = 2'd1;
  localparam logic [1:0] KIND_TICK    = 2'd2;
  localparam logic [1:0] KIND_RECOVER = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN = 3'd4;

  localparam logic [THR_W-1:0]  WINDOW_RST   = 16'd2000;
  localparam logic [THR_W-1:0]  SPEED_RST    = 16'd100;
  localparam logic [MOVE_W-1:0] MOVE_RST     = 24'd100;
  localparam logic [THR_W-1:0]  HOLD_RST     = 16'd1000;
  localparam logic [THR_W-1:0]  COOLDOWN_RST = 16'd3000;

  typedef enum logic [3:0] {
    S_IDLE, S_WR_ODO, S_WR_CMD, S_REC, S_PO_RD, S_PO_CK, S_PC_RD, S_PC_CK,
    S_SUM, S_DIV, S_BASE_RD, S_BASE_CK, S_DISP, S_SQI, S_SQRT, S_FINAL
  } state_t;

  typedef struct packed {
    logic load;
    logic wr_odo;
    logic wr_cmd;
    logic recover;
    logic pop_odo;
    logic pop_cmd;
    logic rd_odo_head;
    logic rd_cmd_head;
    logic sum_init;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic disp_init;
    logic base_cap;
    logic disp_step;
    logic sqrt_init;
    logic sqrt_step;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] kind;
    logic odo_empty;
    logic cmd_empty;
    logic odo_old;
    logic cmd_old;
    logic sum_done;
    logic div_done;
    logic disp_needed;
    logic disp_done;
    logic sqrt_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// ===== src/windowed_stuck_detector.sv =====
// Windowed stuck detector, top level.
// Odometry and speed beats write their queue, then prune entries older than the window
// from both queues; a recovery beat clears the hold and the trigger latch. A tick prunes,
// then runs the one-read-per-cycle queue scans, the bit-serial divider and square root.
// One beat is worked on at a time; a result may wait in its output register while
// the next beat is taken. Synchronous reset empties both queues, clears hold and trigger state.
`timescale 1ns / 1ps
`default_nettype none
module windowed_stuck_detector #(
  parameter int ODO_DEPTH = wsd_pkg::ODO_DEPTH_DEF,
  parameter int CMD_DEPTH = wsd_pkg::CMD_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic [1:0]                            command,
  input  wire logic [wsd_pkg::TIME_W-1:0]            time_ms,
  input  wire logic signed [wsd_pkg::POS_W-1:0]      pos_x,
  input  wire logic signed [wsd_pkg::POS_W-1:0]      pos_y,
  input  wire logic signed [wsd_pkg::SPEED_W-1:0]    speed,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       trigger,
  output logic                                       hold_valid,
  output logic [wsd_pkg::TIME_W-1:0]                 hold_age,
  output logic [wsd_pkg::MAG_W-1:0]                  speed_mean,
  output logic [wsd_pkg::MOVE_W-1:0]                 displacement,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wsd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [wsd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  wsd_pkg::ctrl_t   ctl;
  wsd_pkg::status_t st;

  assign cfg_ready = 1'b1;

  wsd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .command    (command),
    .st         (st),
    .ctl        (ctl),
    .item_stall (item_stall)
  );

  wsd_dp #(.ODO_DEPTH(ODO_DEPTH), .CMD_DEPTH(CMD_DEPTH)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .command      (command),
    .time_ms      (time_ms),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .speed        (speed),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .trigger      (trigger),
    .hold_valid   (hold_valid),
    .hold_age     (hold_age),
    .speed_mean   (speed_mean),
    .displacement (displacement)
  );

endmodule
`default_nettype wire

// ===== src/wsd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module wsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/wsd_ctrl.sv =====
// Controller state machine of the windowed stuck detector.
// Depends on wsd_pkg; drives the datapath through wsd_pkg::ctrl_t.
`timescale 1ns / 1ps
`default_nettype none
module wsd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  input  wire logic [1:0]       command,
  input  wire wsd_pkg::status_t st,
  output wsd_pkg::ctrl_t        ctl,
  output logic                  item_stall
);

  wsd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    logic done_prune;
    done_prune = 1'b0;
    ctl        = '0;
    state_next = state;
    item_stall = (state != wsd_pkg::S_IDLE);
    case (state)
      wsd_pkg::S_IDLE: begin
        if (item_valid) begin
          ctl.load = 1'b1;
          case (command)
            wsd_pkg::KIND_ODO:   state_next = wsd_pkg::S_WR_ODO;
            wsd_pkg::KIND_SPEED: state_next = wsd_pkg::S_WR_CMD;
            wsd_pkg::KIND_TICK:  state_next = wsd_pkg::S_PO_RD;
            default:             state_next = wsd_pkg::S_REC;
          endcase
        end
      end
      wsd_pkg::S_WR_ODO: begin
        ctl.wr_odo = 1'b1;
        state_next = wsd_pkg::S_PO_RD;
      end
      wsd_pkg::S_WR_CMD: begin
        ctl.wr_cmd = 1'b1;
        state_next = wsd_pkg::S_PO_RD;
      end
      wsd_pkg::S_REC: begin
        ctl.recover = 1'b1;
        state_next  = wsd_pkg::S_IDLE;
      end
      wsd_pkg::S_PO_RD: begin
        if (st.odo_empty) begin
          state_next = wsd_pkg::S_PC_RD;
        end else begin
          ctl.rd_odo_head = 1'b1;
          state_next      = wsd_pkg::S_PO_CK;
        end
      end
      wsd_pkg::S_PO_CK: begin
        if (st.odo_old) begin
          ctl.pop_odo = 1'b1;
          state_next  = wsd_pkg::S_PO_RD;
        end else begin
          state_next = wsd_pkg::S_PC_RD;
        end
      end
      wsd_pkg::S_PC_RD: begin
        if (st.cmd_empty) begin
          done_prune = 1'b1;
        end else begin
          ctl.rd_cmd_head = 1'b1;
          state_next      = wsd_pkg::S_PC_CK;
        end
      end
      wsd_pkg::S_PC_CK: begin
        if (st.cmd_old) begin
          ctl.pop_cmd = 1'b1;
          state_next  = wsd_pkg::S_PC_RD;
        end else begin
          done_prune = 1'b1;
        end
      end
      wsd_pkg::S_SUM: begin
        if (st.sum_done) begin
          ctl.div_init = 1'b1;
          state_next   = wsd_pkg::S_DIV;
        end else begin
          ctl.sum_step = 1'b1;
        end
      end
      wsd_pkg::S_DIV: begin
        if (st.div_done) begin
          ctl.disp_init = 1'b1;
          state_next    = st.disp_needed ? wsd_pkg::S_BASE_RD : wsd_pkg::S_SQI;
        end else begin
          ctl.div_step = 1'b1;
        end
      end
      wsd_pkg::S_BASE_RD: begin
        ctl.rd_odo_head = 1'b1;
        state_next      = wsd_pkg::S_BASE_CK;
      end
      wsd_pkg::S_BASE_CK: begin
        ctl.base_cap = 1'b1;
        state_next   = wsd_pkg::S_DISP;
      end
      wsd_pkg::S_DISP: begin
        if (st.disp_done) begin
          state_next = wsd_pkg::S_SQI;
        end else begin
          ctl.disp_step = 1'b1;
        end
      end
      wsd_pkg::S_SQI: begin
        ctl.sqrt_init = 1'b1;
        state_next    = wsd_pkg::S_SQRT;
      end
      wsd_pkg::S_SQRT: begin
        if (st.sqrt_done) begin
          state_next = wsd_pkg::S_FINAL;
        end else begin
          ctl.sqrt_step = 1'b1;
        end
      end
      wsd_pkg::S_FINAL: begin
        if (!st.out_busy) begin
          ctl.finish = 1'b1;
          state_next = wsd_pkg::S_IDLE;
        end
      end
      default: state_next = wsd_pkg::S_IDLE;
    endcase
    // Only a tick goes on to the statistics once both queues are pruned.
    if (done_prune) begin
      if (st.kind == wsd_pkg::KIND_TICK) begin
        ctl.sum_init = 1'b1;
        state_next   = wsd_pkg::S_SUM;
      end else begin
        state_next = wsd_pkg::S_IDLE;
      end
    end
  end

endmodule
`default_nettype wire

// ===== src/wsd_dp.sv =====
// Datapath of the windowed stuck detector: queues, sum, divider, distance scan,
// square root, hold and trigger logic. Depends on wsd_pkg and wsd_ram.
`timescale 1ns / 1ps
`default_nettype none
module wsd_dp #(
  parameter int ODO_DEPTH = wsd_pkg::ODO_DEPTH_DEF,
  parameter int CMD_DEPTH = wsd_pkg::CMD_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire wsd_pkg::ctrl_t                        ctl,
  output wsd_pkg::status_t                           st,
  input  wire logic [1:0]                            command,
  input  wire logic [wsd_pkg::TIME_W-1:0]            time_ms,
  input  wire logic signed [wsd_pkg::POS_W-1:0]      pos_x,
  input  wire logic signed [wsd_pkg::POS_W-1:0]      pos_y,
  input  wire logic signed [wsd_pkg::SPEED_W-1:0]    speed,
  input  wire logic                                  cfg_valid,
  input  wire logic [wsd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [wsd_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic                                       trigger,
  output logic                                       hold_valid,
  output logic [wsd_pkg::TIME_W-1:0]                 hold_age,
  output logic [wsd_pkg::MAG_W-1:0]                  speed_mean,
  output logic [wsd_pkg::MOVE_W-1:0]                 displacement
);

  localparam int OA_W    = $clog2(ODO_DEPTH);
  localparam int OC_W    = $clog2(ODO_DEPTH + 1);
  localparam int CA_W    = $clog2(CMD_DEPTH);
  localparam int CC_W    = $clog2(CMD_DEPTH + 1);
  localparam int SUM_W   = wsd_pkg::MAG_W + CC_W;
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int SCNT_W  = $clog2(wsd_pkg::ROOT_W + 1);
  localparam int TW      = wsd_pkg::TIME_W;
  localparam int PW      = wsd_pkg::POS_W;
  localparam int ODO_W   = TW + 2 * PW;
  localparam int CMDE_W  = TW + wsd_pkg::MAG_W;

  function automatic logic [OA_W-1:0] odo_inc(input logic [OA_W-1:0] p);
    return (p == OA_W'(ODO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [CA_W-1:0] cmd_inc(input logic [CA_W-1:0] p);
    return (p == CA_W'(CMD_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Configuration registers; a written zero selects the reset value.
  logic [wsd_pkg::THR_W-1:0]  window_ms, speed_thr, hold_ms, cooldown_ms;
  logic [wsd_pkg::MOVE_W-1:0] move_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms   <= wsd_pkg::WINDOW_RST;
      speed_thr   <= wsd_pkg::SPEED_RST;
      move_thr    <= wsd_pkg::MOVE_RST;
      hold_ms     <= wsd_pkg::HOLD_RST;
      cooldown_ms <= wsd_pkg::COOLDOWN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        wsd_pkg::REG_WINDOW: window_ms <= (cfg_data[15:0] == '0) ?
                                          wsd_pkg::WINDOW_RST : cfg_data[15:0];
        wsd_pkg::REG_SPEED: speed_thr <= (cfg_data[15:0] == '0) ?
                                         wsd_pkg::SPEED_RST : cfg_data[15:0];
        wsd_pkg::REG_MOVE: move_thr <= (cfg_data == '0) ? wsd_pkg::MOVE_RST : cfg_data;
        wsd_pkg::REG_HOLD: hold_ms <= (cfg_data[15:0] == '0) ?
                                      wsd_pkg::HOLD_RST : cfg_data[15:0];
        wsd_pkg::REG_COOLDOWN: cooldown_ms <= (cfg_data[15:0] == '0) ?
                                              wsd_pkg::COOLDOWN_RST : cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Item registers.
  logic [1:0]                  kind;
  logic [TW-1:0]               now;
  logic signed [PW-1:0]        ix, iy;
  logic [wsd_pkg::MAG_W-1:0]   mag;
  logic [wsd_pkg::SPEED_W-1:0] abs_speed;

  assign abs_speed = speed[wsd_pkg::SPEED_W-1] ? 17'(-speed) : 17'(speed);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind <= command;
      now  <= time_ms;
      ix   <= pos_x;
      iy   <= pos_y;
      // The most negative speed has a magnitude one past the field range.
      mag  <= abs_speed[wsd_pkg::SPEED_W-1] ? '1 : abs_speed[wsd_pkg::MAG_W-1:0];
    end
  end

  // Queue bookkeeping.
  logic [OA_W-1:0] odo_head, odo_head_d, odo_ptr, odo_waddr, odo_raddr;
  logic [OC_W-1:0] odo_count, odo_count_d, odo_idx;
  logic [OA_W:0]   odo_wsum;
  logic [CA_W-1:0] cmd_head, cmd_head_d, cmd_ptr, cmd_waddr, cmd_raddr;
  logic [CC_W-1:0] cmd_count, cmd_count_d, cmd_idx;
  logic [CA_W:0]   cmd_wsum;
  logic [ODO_W-1:0]  odo_rdata;
  logic [CMDE_W-1:0] cmd_rdata;

  // A full queue drops its oldest entry before the new one goes in.
  always_comb begin
    if (odo_count == OC_W'(ODO_DEPTH)) begin
      odo_head_d  = odo_inc(odo_head);
      odo_count_d = OC_W'(ODO_DEPTH - 1);
    end else begin
      odo_head_d  = odo_head;
      odo_count_d = odo_count;
    end
    odo_wsum  = (OA_W + 1)'(odo_head_d) + (OA_W + 1)'(odo_count_d);
    odo_waddr = (odo_wsum >= (OA_W + 1)'(ODO_DEPTH)) ?
                OA_W'(odo_wsum - (OA_W + 1)'(ODO_DEPTH)) : OA_W'(odo_wsum);
    if (cmd_count == CC_W'(CMD_DEPTH)) begin
      cmd_head_d  = cmd_inc(cmd_head);
      cmd_count_d = CC_W'(CMD_DEPTH - 1);
    end else begin
      cmd_head_d  = cmd_head;
      cmd_count_d = cmd_count;
    end
    cmd_wsum  = (CA_W + 1)'(cmd_head_d) + (CA_W + 1)'(cmd_count_d);
    cmd_waddr = (cmd_wsum >= (CA_W + 1)'(CMD_DEPTH)) ?
                CA_W'(cmd_wsum - (CA_W + 1)'(CMD_DEPTH)) : CA_W'(cmd_wsum);
  end

  assign odo_raddr = ctl.rd_odo_head ? odo_head : odo_ptr;
  assign cmd_raddr = ctl.rd_cmd_head ? cmd_head : cmd_ptr;

  wsd_ram #(.WIDTH(ODO_W), .DEPTH(ODO_DEPTH)) u_odo_ram (
    .clk   (clk),
    .we    (ctl.wr_odo),
    .waddr (odo_waddr),
    .wdata ({now, ix, iy}),
    .raddr (odo_raddr),
    .rdata (odo_rdata)
  );

  wsd_ram #(.WIDTH(CMDE_W), .DEPTH(CMD_DEPTH)) u_cmd_ram (
    .clk   (clk),
    .we    (ctl.wr_cmd),
    .waddr (cmd_waddr),
    .wdata ({now, mag}),
    .raddr (cmd_raddr),
    .rdata (cmd_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      odo_head  <= '0;
      odo_count <= '0;
      cmd_head  <= '0;
      cmd_count <= '0;
    end else begin
      if (ctl.wr_odo) begin
        odo_head  <= odo_head_d;
        odo_count <= odo_count_d + 1'b1;
      end else if (ctl.pop_odo) begin
        odo_head  <= odo_inc(odo_head);
        odo_count <= odo_count - 1'b1;
      end
      if (ctl.wr_cmd) begin
        cmd_head  <= cmd_head_d;
        cmd_count <= cmd_count_d + 1'b1;
      end else if (ctl.pop_cmd) begin
        cmd_head  <= cmd_inc(cmd_head);
        cmd_count <= cmd_count - 1'b1;
      end
    end
  end

  // Speed sum: one read issued per cycle, accumulated in the cycle after.
  logic [SUM_W-1:0] acc, prod, quo;
  logic [CC_W:0]    drem, drem_s;
  logic [DCNT_W-1:0] dcnt;
  logic             sum_pend;

  always_ff @(posedge clk) begin
    if (ctl.sum_init) begin
      cmd_ptr  <= cmd_head;
      cmd_idx  <= '0;
      sum_pend <= 1'b0;
      acc      <= '0;
    end else if (ctl.sum_step) begin
      if (cmd_idx != cmd_count) begin
        cmd_ptr  <= cmd_inc(cmd_ptr);
        cmd_idx  <= cmd_idx + 1'b1;
        sum_pend <= 1'b1;
      end else begin
        sum_pend <= 1'b0;
      end
      if (sum_pend) begin
        acc <= acc + SUM_W'(cmd_rdata[wsd_pkg::MAG_W-1:0]);
      end
    end
  end

  // Restoring divider, one quotient bit per cycle.
  assign drem_s = {drem[CC_W-1:0], quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (ctl.div_init) begin
      quo  <= acc;
      drem <= '0;
      dcnt <= '0;
      prod <= SUM_W'(speed_thr) * SUM_W'(cmd_count);
    end else if (ctl.div_step) begin
      dcnt <= dcnt + 1'b1;
      if (drem_s >= (CC_W + 1)'(cmd_count)) begin
        drem <= drem_s - (CC_W + 1)'(cmd_count);
        quo  <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        drem <= drem_s;
        quo  <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  // Distance scan: read, square, then sum and keep the largest.
  logic signed [PW-1:0]         bx, by, rx, ry;
  logic signed [PW:0]           dx, dy;
  logic signed [wsd_pkg::D2_W-1:0] sqx_c, sqy_c;
  logic [wsd_pkg::D2_W-1:0]     sqx, sqy, d2, best;
  logic                         v1, v2;

  assign rx    = odo_rdata[2*PW-1:PW];
  assign ry    = odo_rdata[PW-1:0];
  assign dx    = (PW + 1)'(rx) - (PW + 1)'(bx);
  assign dy    = (PW + 1)'(ry) - (PW + 1)'(by);
  assign sqx_c = dx * dx;
  assign sqy_c = dy * dy;
  assign d2    = sqx + sqy;

  always_ff @(posedge clk) begin
    if (ctl.disp_init) begin
      odo_ptr <= odo_head;
      odo_idx <= '0;
      v1      <= 1'b0;
      v2      <= 1'b0;
      best    <= '0;
    end else if (ctl.base_cap) begin
      bx <= rx;
      by <= ry;
    end else if (ctl.disp_step) begin
      if (odo_idx != odo_count) begin
        odo_ptr <= odo_inc(odo_ptr);
        odo_idx <= odo_idx + 1'b1;
        v1      <= 1'b1;
      end else begin
        v1 <= 1'b0;
      end
      sqx <= $unsigned(sqx_c);
      sqy <= $unsigned(sqy_c);
      v2  <= v1;
      if (v2 && (d2 > best)) begin
        best <= d2;
      end
    end
  end

  // Floor square root, two radicand bits per cycle.
  logic [wsd_pkg::D2_W-1:0]   sv;
  logic [wsd_pkg::ROOT_W-1:0] root;
  logic [wsd_pkg::REM_W-1:0]  srem, srem_s, trial;
  logic [SCNT_W-1:0]          scnt;

  assign srem_s = {srem[wsd_pkg::REM_W-3:0], sv[wsd_pkg::D2_W-1 -: 2]};
  assign trial  = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (ctl.sqrt_init) begin
      sv   <= best;
      root <= '0;
      srem <= '0;
      scnt <= '0;
    end else if (ctl.sqrt_step) begin
      sv   <= {sv[wsd_pkg::D2_W-3:0], 2'b00};
      scnt <= scnt + 1'b1;
      if (srem_s >= trial) begin
        srem <= srem_s - trial;
        root <= {root[wsd_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        srem <= srem_s;
        root <= {root[wsd_pkg::ROOT_W-2:0], 1'b0};
      end
    end
  end

  // Hold timer and trigger.
  logic          hold_on, latched, recovered;
  logic [TW-1:0] hold_start, recovery_end;
  logic          hold_n, latch_n, few, fast, still, cool;
  logic [TW-1:0] start_n;
  logic [wsd_pkg::MOVE_W-1:0] disp_v;
  logic [wsd_pkg::MAG_W-1:0]  mean_v;

  assign disp_v = root[wsd_pkg::ROOT_W-1] ? '1 : root[wsd_pkg::MOVE_W-1:0];
  assign mean_v = (cmd_count == '0) ? '0 : quo[wsd_pkg::MAG_W-1:0];
  assign few    = (odo_count < OC_W'(wsd_pkg::MIN_ODO)) ||
                  (cmd_count < CC_W'(wsd_pkg::MIN_CMD));
  assign fast   = acc > prod;
  assign still  = disp_v < move_thr;
  assign cool   = !recovered || ((now - recovery_end) >= TW'(cooldown_ms));

  always_comb begin
    hold_n  = hold_on;
    start_n = hold_start;
    latch_n = latched;
    if (few) begin
      hold_n = 1'b0;
    end else begin
      if (fast && still) begin
        if (!hold_on) begin
          hold_n  = 1'b1;
          start_n = now;
        end
      end else begin
        hold_n = 1'b0;
      end
      if (!latched && hold_n && cool && ((now - start_n) >= TW'(hold_ms))) begin
        latch_n = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_on      <= 1'b0;
      hold_start   <= '0;
      latched      <= 1'b0;
      recovery_end <= '0;
      recovered    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.recover) begin
        latched      <= 1'b0;
        hold_on      <= 1'b0;
        recovery_end <= now;
        recovered    <= 1'b1;
      end else if (ctl.finish) begin
        hold_on    <= hold_n;
        hold_start <= start_n;
        latched    <= latch_n;
      end
      if (ctl.finish) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      trigger      <= latch_n;
      hold_valid   <= hold_n;
      hold_age     <= hold_n ? (now - start_n) : '0;
      speed_mean   <= mean_v;
      displacement <= disp_v;
    end
  end

  // Status back to the controller.
  always_comb begin
    st             = '0;
    st.kind        = kind;
    st.odo_empty   = (odo_count == '0);
    st.cmd_empty   = (cmd_count == '0);
    st.odo_old     = (now - odo_rdata[ODO_W-1 -: TW]) > TW'(window_ms);
    st.cmd_old     = (now - cmd_rdata[CMDE_W-1 -: TW]) > TW'(window_ms);
    st.sum_done    = (cmd_idx == cmd_count) && !sum_pend;
    st.div_done    = (dcnt == DCNT_W'(SUM_W));
    st.disp_needed = (odo_count >= OC_W'(wsd_pkg::MIN_ODO));
    st.disp_done   = (odo_idx == odo_count) && !v1 && !v2;
    st.sqrt_done   = (scnt == SCNT_W'(wsd_pkg::ROOT_W));
    st.out_busy    = result_valid && result_stall;
  end

endmodule
`default_nettype wire
